[rtl/crie_pkg.sv]
// crie_pkg: shared types, constants and helpers for the consecutive run interval encoder
// no dependencies
`timescale 1ns / 1ps

package crie_pkg;

  localparam int ValueW     = 64;
  localparam int IndexW     = 32;
  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  // one interval word as it leaves the block
  typedef struct packed {
    logic [ValueW-1:0] range_low;
    logic [ValueW-1:0] range_high;
    logic [IndexW-1:0] range_index;
    logic              final_range;
  } range_t;

  // up to two intervals raised by one accepted element, first slot fills first
  typedef struct packed {
    logic   valid0;
    logic   valid1;
    range_t r0;
    range_t r1;
  } range_pair_t;

  // order the run ends by direction: a falling run starts at its high end
  function automatic range_t make_range(input logic [ValueW-1:0] start,
                                        input logic [ValueW-1:0] prev,
                                        input logic              falling,
                                        input logic [IndexW-1:0] idx,
                                        input logic              last);
    range_t r;
    if (falling) begin
      r.range_low  = prev;
      r.range_high = start;
    end else begin
      r.range_low  = start;
      r.range_high = prev;
    end
    r.range_index = idx;
    r.final_range = last;
    return r;
  endfunction

endpackage

[rtl/crie_element_if.sv]
// crie_element_if: valid/ready channel carrying one list element word
// depends on crie_pkg
`timescale 1ns / 1ps

interface crie_element_if
  import crie_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

[rtl/crie_range_if.sv]
// crie_range_if: valid/ready channel carrying one interval word
// depends on crie_pkg
`timescale 1ns / 1ps

interface crie_range_if
  import crie_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] range_low;
  logic [ValueW-1:0] range_high;
  logic [IndexW-1:0] range_index;
  logic              final_range;

  modport source (output valid, output range_low, output range_high,
                  output range_index, output final_range, input ready);
  modport sink   (input valid, input range_low, input range_high,
                  input range_index, input final_range, output ready);
endinterface

[rtl/crie_run_tracker.sv]
// crie_run_tracker: run state registers and the interval decision for each element
// depends on crie_pkg
`timescale 1ns / 1ps

module crie_run_tracker
  import crie_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [ValueW-1:0] value,
  input  logic              end_of_list,
  output range_pair_t       results
);

  logic [ValueW-1:0] run_start, run_start_next;
  logic [ValueW-1:0] previous_value, previous_value_next;
  logic              run_falling, run_falling_next;
  logic              direction_known, direction_known_next;
  logic              list_started, list_started_next;
  logic [IndexW-1:0] ranges_emitted, ranges_emitted_next;

  // state after the element is folded in, before the list end is applied
  logic [ValueW-1:0] mid_start, mid_prev;
  logic              mid_falling, mid_known;
  logic              up, down, brk;
  logic [IndexW-1:0] eol_index;
  range_t            brk_range, eol_range;

  // start, continue or break the open run
  always_comb begin
    up          = (value == previous_value + 64'd1);
    down        = (value == previous_value - 64'd1);
    mid_start   = run_start;
    mid_prev    = previous_value;
    mid_falling = run_falling;
    mid_known   = direction_known;
    brk         = 1'b0;
    priority if (!list_started) begin
      mid_start   = value;
      mid_prev    = value;
      mid_falling = 1'b0;
      mid_known   = 1'b0;
    end else if (up && (!direction_known || !run_falling)) begin
      mid_falling = 1'b0;
      mid_known   = 1'b1;
      mid_prev    = value;
    end else if (down && (!direction_known || run_falling)) begin
      mid_falling = 1'b1;
      mid_known   = 1'b1;
      mid_prev    = value;
    end else begin
      brk         = 1'b1;
      mid_start   = value;
      mid_prev    = value;
      mid_falling = 1'b0;
      mid_known   = 1'b0;
    end
  end

  // intervals for a broken run and for the list end
  always_comb begin
    brk_range = make_range(run_start, previous_value, run_falling && direction_known,
                           ranges_emitted, 1'b0);
    eol_index = ranges_emitted + {{(IndexW-1){1'b0}}, brk};
    eol_range = make_range(mid_start, mid_prev, mid_falling && mid_known,
                           eol_index, 1'b1);
    results.valid0 = accept && (brk || end_of_list);
    results.valid1 = accept && brk && end_of_list;
    results.r0     = brk ? brk_range : eol_range;
    results.r1     = eol_range;
  end

  // next state, list end returns everything to idle
  always_comb begin
    run_start_next       = run_start;
    previous_value_next  = previous_value;
    run_falling_next     = run_falling;
    direction_known_next = direction_known;
    list_started_next    = list_started;
    ranges_emitted_next  = ranges_emitted;
    if (accept) begin
      if (end_of_list) begin
        run_start_next       = '0;
        previous_value_next  = '0;
        run_falling_next     = 1'b0;
        direction_known_next = 1'b0;
        list_started_next    = 1'b0;
        ranges_emitted_next  = '0;
      end else begin
        run_start_next       = mid_start;
        previous_value_next  = mid_prev;
        run_falling_next     = mid_falling;
        direction_known_next = mid_known;
        list_started_next    = 1'b1;
        ranges_emitted_next  = eol_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_start       <= '0;
      previous_value  <= '0;
      run_falling     <= 1'b0;
      direction_known <= 1'b0;
      list_started    <= 1'b0;
      ranges_emitted  <= '0;
    end else begin
      run_start       <= run_start_next;
      previous_value  <= previous_value_next;
      run_falling     <= run_falling_next;
      direction_known <= direction_known_next;
      list_started    <= list_started_next;
      ranges_emitted  <= ranges_emitted_next;
    end
  end

  // second slot only with a break on the list end
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    results.valid1 |-> results.valid0 && !results.r0.final_range && results.r1.final_range)
    else $error("second interval without a closed first one");

  // list end clears the run state
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_list |=> !list_started && ranges_emitted == '0 && !direction_known)
    else $error("state not cleared after list end");

  // a known direction needs a list in progress
  a_known_started: assert property (@(posedge clk) disable iff (rst)
    direction_known |-> list_started)
    else $error("direction known with no open list");

endmodule

[rtl/crie_out_queue.sv]
// crie_out_queue: four-entry interval queue, takes up to two words, gives one per cycle while out_ready is high
// depends on crie_pkg
`timescale 1ns / 1ps

module crie_out_queue
  import crie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  range_pair_t push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output range_t      out_word
);

  range_t            entries [QueueDepth];
  logic [PtrW-1:0]   wr_ptr, wr_ptr_next;
  logic [PtrW-1:0]   rd_ptr, rd_ptr_next;
  logic [CountW-1:0] count, count_next;
  logic [CountW-1:0] push_n;
  logic              pop;

  // room for a worst case element, two intervals
  assign room      = (count <= CountW'(QueueDepth - 2));
  assign out_valid = (count != '0);
  assign out_word  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  // pointer and fill bookkeeping
  always_comb begin
    push_n      = CountW'(push.valid0) + CountW'(push.valid1);
    wr_ptr_next = wr_ptr + PtrW'(push_n);
    rd_ptr_next = rd_ptr + PtrW'(pop);
    count_next  = count + push_n - CountW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      entries[wr_ptr + PtrW'(1)] <= push.r1;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(QueueDepth))
    else $error("queue overfilled");

  a_pair_fits: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> push.valid0 && room)
    else $error("interval pair pushed without room");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !pop && !push.valid0 |=> count == $past(count) && rd_ptr == $past(rd_ptr))
    else $error("queue moved with no push or pop");

endmodule

[rtl/consecutive_run_interval_encoder_core.sv]
// consecutive_run_interval_encoder_core: top level of the run interval encoder
// depends on crie_pkg, crie_element_if, crie_range_if, crie_run_tracker, crie_out_queue
`timescale 1ns / 1ps

// Takes one 64-bit list element per cycle and emits one interval word for every
// run of values that step by exactly +1 or -1 (modulo 2^64); a change of direction
// starts a new run. The element flagged end_of_list closes the open run, so it can
// raise two words (broken run, then the one-element tail run), the last carrying
// final_range; after it the index restarts at 0. Elements are taken every cycle
// while the four-word output queue has two free slots; a result word is queued as its
// element is accepted, and the queue drains one word a cycle, so the sustained rate
// is one element per cycle unless the sink stalls or list ends that break a run keep
// raising two words per element. Ready stays low during reset.

module consecutive_run_interval_encoder_core
  import crie_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  crie_element_if.sink     elements,
  crie_range_if.source     intervals
);

  range_pair_t pair;
  range_t      head;
  logic        room;
  logic        accept;

  assign elements.ready = room && !rst;
  assign accept         = elements.valid && room && !rst;

  // run state and interval decision
  crie_run_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .value       (elements.value),
    .end_of_list (elements.end_of_list),
    .results     (pair)
  );

  // result queue between tracker and sink
  crie_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair),
    .room      (room),
    .out_valid (intervals.valid),
    .out_ready (intervals.ready),
    .out_word  (head)
  );

  // drive the output word
  assign intervals.range_low   = head.range_low;
  assign intervals.range_high  = head.range_high;
  assign intervals.range_index = head.range_index;
  assign intervals.final_range = head.final_range;

endmodule
